// ===== design/mute_solo_fader_8ch_defines.svh =====
// Assertion macros shared by the mute/solo fader RTL.
`ifndef MUTE_SOLO_FADER_8CH_DEFINES_SVH
`define MUTE_SOLO_FADER_8CH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/msf_pkg.sv =====
// Types and constants of the mute/solo fader.
package msf_pkg;

  localparam int NUM_CH    = 8;
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 23;
  localparam int STEP_W    = 24;
  localparam int CNT_W     = 4;
  localparam int ACT_W     = 5;
  localparam int IN_W      = 216;
  localparam int OUT_W     = 200;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1511);

  typedef enum logic [1:0] {
    ST_UNMUTED    = 2'd0,
    ST_SOLO       = 2'd1,
    ST_SOLO_MUTED = 2'd2,
    ST_MUTED      = 2'd3
  } btn_e;

  typedef enum logic {
    REG_FADE_STEP   = 1'b0,
    REG_SHRINK_MODE = 1'b1
  } cfg_reg_e;

  // Frame-wide controls broadcast to every lane.
  typedef struct packed {
    logic              accept;
    logic              normal;
    logic              resync;
    logic              flip;
    logic              solo_on;
    logic              solo_new;
    logic [STEP_W-1:0] fade_step;
  } lane_ctrl_t;

endpackage

// ===== design/msf_lane.sv =====
// One channel lane: transition machine, gain ramp and gain multiply.
module msf_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  msf_pkg::lane_ctrl_t                  ctrl_i,
  input  logic                                 lane_act_i,
  input  logic                                 load_i,
  input  logic signed [msf_pkg::SAMPLE_W-1:0]  sample_i,
  input  msf_pkg::btn_e                        button_i,
  output logic signed [msf_pkg::SAMPLE_W-1:0]  sample_o,
  output logic signed [msf_pkg::SAMPLE_W-1:0]  prod_o,
  output logic                                 audible_o,
  output msf_pkg::btn_e                        last_o
);
  import msf_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  typedef struct packed {
    logic [GAIN_W-1:0] g;
    logic              ra;
    logic              rd;
  } fade_t;

  btn_e              last_q, status_q, saved_q;
  logic [GAIN_W-1:0] gain_q;
  logic              ra_q, rd_q;

  btn_e              status_d, saved_d;
  fade_t             f;
  logic              step_nz;
  logic [GAIN_W:0]   up_sum;
  logic              aud_d;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic [GAIN_W-1:0]          gain1_q;
  logic                       aud_q;
  logic signed [PROD_W-1:0]   prod, prod_r;

  function automatic fade_t fade(fade_t fi, logic up, logic nz);
    fade_t fo;
    fo = fi;
    if (nz) begin
      fo.ra = 1'b1;
      fo.rd = !up;
    end else begin
      fo.g  = up ? GAIN_ONE : '0;
      fo.ra = 1'b0;
    end
    return fo;
  endfunction

  assign step_nz = (ctrl_i.fade_step != '0);

  always_comb begin
    status_d = status_q;
    saved_d  = saved_q;
    f.g      = gain_q;
    f.ra     = ra_q;
    f.rd     = rd_q;
    up_sum   = '0;
    // re-sync from the last recorded button after shrink mode
    if (ctrl_i.resync) begin
      f.ra = 1'b0;
      case (last_q)
        ST_UNMUTED: begin
          saved_d = ST_UNMUTED; status_d = ST_UNMUTED; f.g = GAIN_ONE;
        end
        ST_MUTED: begin
          saved_d = ST_MUTED; status_d = ST_MUTED; f.g = '0;
        end
        default: begin
          saved_d  = (last_q == ST_SOLO) ? ST_UNMUTED : ST_MUTED;
          status_d = last_q;
          f.g      = GAIN_ONE;
        end
      endcase
    end
    // solo engaged or released
    if (ctrl_i.flip) begin
      if (ctrl_i.solo_on) begin
        if (status_d == ST_UNMUTED || status_d == ST_MUTED) begin
          f = fade(f, 1'b0, step_nz);
          saved_d = status_d;
        end
      end else if (saved_d == ST_UNMUTED) begin
        f = fade(f, 1'b1, step_nz);
        status_d = ST_UNMUTED;
      end else if (saved_d == ST_MUTED) begin
        f = fade(f, 1'b0, step_nz);
        status_d = ST_MUTED;
      end
    end
    // button change
    if (button_i != last_q) begin
      case (last_q)
        ST_UNMUTED: begin
          if (button_i == ST_MUTED) begin
            saved_d = ST_MUTED;
            if (ctrl_i.normal) f = fade(f, 1'b0, step_nz);
            status_d = ST_MUTED;
          end else if (button_i == ST_SOLO) begin
            if (ctrl_i.normal) f = fade(f, 1'b1, step_nz);
            status_d = ST_SOLO;
            if (!ctrl_i.solo_on) saved_d = ST_UNMUTED;
          end else begin
            if (ctrl_i.normal) f = fade(f, 1'b1, step_nz);
            status_d = ST_SOLO_MUTED;
          end
        end
        ST_MUTED: begin
          if (button_i == ST_UNMUTED) begin
            if (ctrl_i.normal && !ctrl_i.solo_on) f = fade(f, 1'b1, step_nz);
            saved_d = ST_UNMUTED; status_d = ST_UNMUTED;
          end else if (button_i == ST_SOLO) begin
            if (ctrl_i.normal) f = fade(f, 1'b1, step_nz);
            status_d = ST_SOLO;
          end else begin
            if (ctrl_i.normal) f = fade(f, 1'b1, step_nz);
            status_d = ST_SOLO_MUTED;
            if (!ctrl_i.solo_on) saved_d = ST_MUTED;
          end
        end
        ST_SOLO_MUTED: begin
          if (button_i == ST_UNMUTED) begin
            if (ctrl_i.solo_on) begin
              if (ctrl_i.normal) f = fade(f, saved_d != ST_MUTED, step_nz);
              saved_d = ST_UNMUTED;
            end else if (ctrl_i.normal) begin
              f = fade(f, 1'b1, step_nz);
            end
            status_d = ST_UNMUTED;
          end else if (button_i == ST_MUTED) begin
            if (ctrl_i.normal) f = fade(f, 1'b0, step_nz);
            status_d = ST_MUTED;
          end
        end
        default: begin
          if (button_i == ST_UNMUTED) begin
            if (ctrl_i.normal) f = fade(f, !ctrl_i.solo_on, step_nz);
            status_d = ST_UNMUTED;
          end else if (button_i == ST_MUTED) begin
            if (ctrl_i.normal) f = fade(f, 1'b0, step_nz);
            status_d = ST_MUTED;
          end
        end
      endcase
    end
    // advance the ramp, clamp at the bounds
    if (ctrl_i.normal && lane_act_i && f.ra) begin
      if (!f.rd) begin
        up_sum = {1'b0, f.g} + {1'b0, ctrl_i.fade_step};
        if (up_sum > {1'b0, GAIN_ONE}) begin
          f.ra = 1'b0;
          f.g  = GAIN_ONE;
        end else begin
          f.g = up_sum[GAIN_W-1:0];
        end
      end else if (ctrl_i.fade_step > f.g) begin
        f.ra = 1'b0;
        f.g  = '0;
      end else begin
        f.g = f.g - ctrl_i.fade_step;
      end
    end
    aud_d = ctrl_i.solo_new ? (status_d == ST_SOLO || status_d == ST_SOLO_MUTED)
                            : (status_d == ST_UNMUTED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= ST_UNMUTED;
      status_q <= ST_UNMUTED;
      saved_q  <= ST_UNMUTED;
      gain_q   <= GAIN_ONE;
      ra_q     <= 1'b0;
      rd_q     <= 1'b0;
    end else if (ctrl_i.accept) begin
      last_q   <= button_i;
      status_q <= status_d;
      saved_q  <= saved_d;
      gain_q   <= f.g;
      ra_q     <= f.ra;
      rd_q     <= f.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_i;
      gain1_q  <= f.g;
      aud_q    <= aud_d;
    end
  end

  // round half up, floor on the shifted product
  assign prod   = PROD_W'(sample_q) * $signed({1'b0, gain1_q});
  assign prod_r = prod + (PROD_W'(1) << (GAIN_FRAC - 1));
  assign prod_o = prod_r[GAIN_FRAC +: SAMPLE_W];

  assign sample_o  = sample_q;
  assign audible_o = aud_q;
  assign last_o    = last_q;

endmodule

// ===== design/msf_merge.sv =====
// Merging stage: gained slots in normal mode, packed audible slots in shrink mode.
module msf_merge (
  input  logic                                                 clk_i,
  input  logic                                                 load_i,
  input  logic                                                 normal_i,
  input  logic [msf_pkg::NUM_CH-1:0]                           act_mask_i,
  input  logic [msf_pkg::CNT_W-1:0]                            act_cnt_i,
  input  logic [msf_pkg::NUM_CH-1:0]                           audible_i,
  input  logic [msf_pkg::NUM_CH-1:0][msf_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [msf_pkg::NUM_CH-1:0][msf_pkg::SAMPLE_W-1:0]    prod_i,
  output logic [msf_pkg::NUM_CH-1:0][msf_pkg::SAMPLE_W-1:0]    slot_o,
  output logic [msf_pkg::CNT_W-1:0]                            count_o
);
  import msf_pkg::*;

  logic [NUM_CH-1:0][SAMPLE_W-1:0] slot_d, slot_q;
  logic [CNT_W-1:0]                n, cnt_q;

  always_comb begin
    slot_d = '0;
    n      = '0;
    if (normal_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (act_mask_i[c]) slot_d[c] = prod_i[c];
      end
      n = act_cnt_i;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (act_mask_i[c] && audible_i[c]) begin
          slot_d[n[CNT_W-2:0]] = sample_i[c];
          n = n + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= slot_d;
      cnt_q  <= n;
    end
  end

  assign slot_o  = slot_q;
  assign count_o = cnt_q;

endmodule

// ===== design/mute_solo_fader_8ch.sv =====
// Top level of the eight-channel mute/solo fader.
// One item is one frame of eight signed 24-bit samples with the 2-bit button
// code of every channel (0 unmuted, 1 solo, 2 solo-muted, 3 muted) and the
// incoming channel count (0 reads as 1, anything above 8 as 8). The block
// takes one frame per clock while s_axis_tready_o is high and returns its
// result through the lane and merge registers: the edge of acceptance updates
// every lane's channel state and gain and registers the sample with its new
// gain, then each lane multiplies the sample by its Q1.23 gain (one 24x25
// multiplier per lane) and the merge stage registers the result. In normal
// mode slot c carries sample_c * gain_c rounded half up, with out_count equal
// to the channel count; in shrink mode gains are bypassed and the audible
// channels are packed to the front. Gains move by fade_step per frame toward
// 0 or unity; fade_step 0 switches instantly. Write configuration only while
// idle; cfg_ready_o is always high. Backpressure holds the output register
// and, with stage 1 full, the input; s_axis_tready_o stays high as it drains.
`include "mute_solo_fader_8ch_defines.svh"

module mute_solo_fader_8ch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample_0..sample_7 (24 b each), button_codes (16 b), active_channels (5 b)
  input  logic [msf_pkg::IN_W-1:0]      s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // out_0..out_7 (24 b each), out_count (4 b)
  output logic [msf_pkg::OUT_W-1:0]     m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  msf_pkg::cfg_reg_e             cfg_index_i,
  input  logic [msf_pkg::STEP_W-1:0]    cfg_data_i
);
  import msf_pkg::*;

  localparam int BTN_LSB = NUM_CH * SAMPLE_W;
  localparam int ACT_LSB = BTN_LSB + 2 * NUM_CH;

  // configuration registers
  logic [STEP_W-1:0] fade_step_q;
  logic              shrink_q;

  // frame-wide state
  logic solo_on_q, solo_before_q, was_shrunk_q;

  // pipeline valids and stage-1 frame controls
  logic              v1_q, v2_q, en1, en2, accept;
  logic              normal1_q;
  logic [NUM_CH-1:0] act_mask_q, act_mask_d;
  logic [CNT_W-1:0]  act_cnt_q, act_cnt_d;
  logic [ACT_W-1:0]  act_raw;

  logic              any_last_solo, any_new_solo, normal, resync, eff_on, eff_before;
  lane_ctrl_t        ctrl;

  logic [NUM_CH-1:0]               last_solo, new_solo, audible;
  btn_e [NUM_CH-1:0]               last_btn, new_btn;
  logic [NUM_CH-1:0][SAMPLE_W-1:0] lane_sample, lane_prod, slot;
  logic [CNT_W-1:0]                out_count;

  // advance the pipe while the output register is free or being drained
  assign en2             = !v2_q || m_axis_tready_i;
  assign en1             = !v1_q || en2;
  assign s_axis_tready_o = en1;
  assign accept          = s_axis_tvalid_i && en1;
  assign cfg_ready_o     = 1'b1;

  // clamp the channel count to 1..NUM_CH
  assign act_raw = s_axis_tdata_i[ACT_LSB +: ACT_W];
  always_comb begin
    if (act_raw == '0) begin
      act_cnt_d = CNT_W'(1);
    end else if (act_raw > ACT_W'(NUM_CH)) begin
      act_cnt_d = CNT_W'(NUM_CH);
    end else begin
      act_cnt_d = act_raw[CNT_W-1:0];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      act_mask_d[c] = (CNT_W'(c) < act_cnt_d);
      new_btn[c]    = btn_e'(s_axis_tdata_i[BTN_LSB + 2*c +: 2]);
      new_solo[c]   = (new_btn[c] == ST_SOLO) || (new_btn[c] == ST_SOLO_MUTED);
      last_solo[c]  = (last_btn[c] == ST_SOLO) || (last_btn[c] == ST_SOLO_MUTED);
    end
  end

  assign any_last_solo = |last_solo;
  assign any_new_solo  = |new_solo;
  assign normal        = !shrink_q;
  assign resync        = normal && was_shrunk_q;
  // a soloed code at re-sync forces solo on and a pending solo engage
  assign eff_on        = (resync && any_last_solo) ? 1'b1 : solo_on_q;
  assign eff_before    = (resync && any_last_solo) ? 1'b0 : solo_before_q;

  always_comb begin
    ctrl.accept    = accept;
    ctrl.normal    = normal;
    ctrl.resync    = resync;
    ctrl.flip      = normal && (eff_on != eff_before);
    ctrl.solo_on   = normal ? eff_on : solo_on_q;
    ctrl.solo_new  = any_new_solo;
    ctrl.fade_step = fade_step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_step_q <= STEP_RESET;
      shrink_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FADE_STEP:   fade_step_q <= cfg_data_i;
        REG_SHRINK_MODE: shrink_q    <= cfg_data_i[0];
        default:         fade_step_q <= fade_step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solo_on_q     <= 1'b0;
      solo_before_q <= 1'b0;
      was_shrunk_q  <= 1'b0;
    end else if (accept) begin
      solo_on_q    <= any_new_solo;
      was_shrunk_q <= !normal;
      if (normal) solo_before_q <= eff_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      normal1_q  <= normal;
      act_mask_q <= act_mask_d;
      act_cnt_q  <= act_cnt_d;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    msf_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .lane_act_i (act_mask_d[c]),
      .load_i     (en1),
      .sample_i   (s_axis_tdata_i[c*SAMPLE_W +: SAMPLE_W]),
      .button_i   (new_btn[c]),
      .sample_o   (lane_sample[c]),
      .prod_o     (lane_prod[c]),
      .audible_o  (audible[c]),
      .last_o     (last_btn[c])
    );
  end

  msf_merge u_merge (
    .clk_i      (clk_i),
    .load_i     (en2),
    .normal_i   (normal1_q),
    .act_mask_i (act_mask_q),
    .act_cnt_i  (act_cnt_q),
    .audible_i  (audible),
    .sample_i   (lane_sample),
    .prod_i     (lane_prod),
    .slot_o     (slot),
    .count_o    (out_count)
  );

  assign m_axis_tvalid_o = v2_q;
  assign m_axis_tdata_o  = OUT_W'({out_count, slot});

  `MSF_ASSERT_NXT(a_accept_fills_s1, accept, v1_q, "accepted request not in stage 1")
  `MSF_ASSERT_IMP(a_count_range, m_axis_tvalid_o, out_count <= CNT_W'(NUM_CH),
                  "out_count beyond channel count")
  `MSF_ASSERT_IMP(a_solo_tracks_buttons, 1'b1, solo_on_q == any_last_solo,
                  "solo flag disagrees with recorded buttons")

endmodule
